[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/rlbd_pkg.sv]
// ----------------------------------------------------------------------------
// rlbd_pkg
// Constants, field widths and reset tables of the resistor ladder decoder
// ----------------------------------------------------------------------------
package rlbd_pkg;

    // default configuration of the block
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int SAMPLE_BITS_DEF = 10;

    // fixed field widths of the result word
    localparam int BUTTON_INDEX_BITS = 2;
    localparam int KEY_CODE_BITS     = 8;
    localparam int COUNT_BITS        = 4;

    // counter saturation and reset thresholds
    localparam logic [COUNT_BITS-1:0] STREAK_MAX    = 4'd15;
    localparam logic [COUNT_BITS-1:0] PRESS_RESET   = 4'd4;
    localparam logic [COUNT_BITS-1:0] RELEASE_RESET = 4'd4;

    // event kinds
    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // reset contents of the button table, up to eight entries
    localparam int RESET_ENTRIES = 8;
    localparam logic [15:0] RESET_LOW  [RESET_ENTRIES] =
        '{16'd945, 16'd985, 16'd800, 16'd885, 16'd0, 16'd0, 16'd0, 16'd0};
    localparam logic [15:0] RESET_HIGH [RESET_ENTRIES] =
        '{16'd965, 16'd1020, 16'd830, 16'd915, 16'd0, 16'd0, 16'd0, 16'd0};
    localparam logic        RESET_TYPE [RESET_ENTRIES] =
        '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam logic [7:0]  RESET_CODE [RESET_ENTRIES] =
        '{8'd201, 8'd200, 8'd118, 8'd110, 8'd0, 8'd0, 8'd0, 8'd0};

    // packed reset entry; fields may overlap for narrow samples, as in the packing
    function automatic logic [63:0] reset_entry(input int sample_bits, input int idx);
        logic [63:0] word;
        word = 64'(RESET_LOW[idx])
             | (64'(RESET_HIGH[idx]) << sample_bits)
             | (64'(RESET_TYPE[idx]) << (2 * sample_bits))
             | (64'(RESET_CODE[idx]) << (2 * sample_bits + 1));
        return word;
    endfunction

endpackage

[design/rlbd_sample_if.sv]
// ----------------------------------------------------------------------------
// rlbd_sample_if
// Valid/ready channel carrying one ADC sample word
// ----------------------------------------------------------------------------
interface rlbd_sample_if #(
    parameter int SAMPLE_BITS = rlbd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[design/rlbd_event_if.sv]
// ----------------------------------------------------------------------------
// rlbd_event_if
// Valid/ready channel carrying one press or release event word
// ----------------------------------------------------------------------------
interface rlbd_event_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   event_kind;
    logic [rlbd_pkg::BUTTON_INDEX_BITS-1:0] button_index;
    logic                                   output_type;
    logic [rlbd_pkg::KEY_CODE_BITS-1:0]     key_code;

    modport source (output valid, output event_kind, output button_index,
                    output output_type, output key_code, input ready);
    modport sink   (input valid, input event_kind, input button_index,
                    input output_type, input key_code, output ready);
endinterface

[design/resistor_ladder_button_decoder_unit.sv]
// ----------------------------------------------------------------------------
// resistor_ladder_button_decoder_unit
// Debounced button decoder for a resistor ladder sampled by an ADC
// ----------------------------------------------------------------------------
// Takes one ADC sample word per clock and emits a press event after
// press_count matching samples and a release event after release_count
// out-of-window samples of the held button. A sample is registered on
// acceptance, decoded by the window compares and streak logic, and the
// event is held in the output register, so a sample passes the input
// register and then the output register before its event appears; the
// window compare and counter update in the decode stage set the rate of one
// sample per clock, which holds as long as the event sink keeps its ready high.
module resistor_ladder_button_decoder_unit #(
    parameter int NUM_BUTTONS = rlbd_pkg::NUM_BUTTONS_DEF,
    parameter int SAMPLE_BITS = rlbd_pkg::SAMPLE_BITS_DEF,
    localparam int ENTRY_BITS = 2 * SAMPLE_BITS + 1 + rlbd_pkg::KEY_CODE_BITS,
    localparam int INDEX_BITS = $clog2(NUM_BUTTONS + 2),
    localparam int HELD_BITS  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rlbd_sample_if.sink           samples,
    rlbd_event_if.source          events,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_index,
    input  logic [ENTRY_BITS-1:0] wr_data
);

`include "assert_macros.svh"

    localparam int CB = rlbd_pkg::COUNT_BITS;

    // configuration registers
    logic [ENTRY_BITS-1:0] entry_reg [NUM_BUTTONS];
    logic [CB-1:0]         press_count_reg;
    logic [CB-1:0]         release_count_reg;

    // input stage
    logic                   s1_valid_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;

    // decoder state
    logic                 holding_reg, holding_next;
    logic [CB-1:0]        streak_reg, streak_next;
    logic [HELD_BITS-1:0] held_reg, held_next;

    // output stage
    logic                                   out_valid_reg, out_valid_next;
    logic                                   out_kind_reg, out_kind_next;
    logic [rlbd_pkg::BUTTON_INDEX_BITS-1:0] out_index_reg, out_index_next;
    logic                                   out_type_reg, out_type_next;
    logic [rlbd_pkg::KEY_CODE_BITS-1:0]     out_code_reg, out_code_next;

    logic                   advance;
    logic                   emit;
    logic [NUM_BUTTONS-1:0] hit;
    logic                   any_hit;
    logic [HELD_BITS-1:0]   first_hit;
    logic [HELD_BITS-1:0]   emit_button;
    logic [CB-1:0]          streak_bump;

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                entry_reg[b] <= ENTRY_BITS'(rlbd_pkg::reset_entry(SAMPLE_BITS, b));
            end
            press_count_reg   <= rlbd_pkg::PRESS_RESET;
            release_count_reg <= rlbd_pkg::RELEASE_RESET;
        end
        else if (wr_en)
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                if (wr_index == INDEX_BITS'(b))
                begin
                    entry_reg[b] <= wr_data;
                end
            end
            if (wr_index == INDEX_BITS'(NUM_BUTTONS))
            begin
                press_count_reg <= wr_data[CB-1:0];
            end
            if (wr_index == INDEX_BITS'(NUM_BUTTONS + 1))
            begin
                release_count_reg <= wr_data[CB-1:0];
            end
        end
    end

    // the decode stage moves when the output register is free or drains
    assign advance       = s1_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_sample_reg <= samples.sample;
        end
    end

    // window compares, strictly inside low and high
    always_comb
    begin
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            hit[b] = (s1_sample_reg > entry_reg[b][SAMPLE_BITS-1:0])
                  && (s1_sample_reg < entry_reg[b][2*SAMPLE_BITS-1:SAMPLE_BITS]);
        end
    end

    // lowest-numbered matching window wins
    always_comb
    begin
        first_hit = '0;
        for (int b = NUM_BUTTONS - 1; b >= 0; b--)
        begin
            if (hit[b])
            begin
                first_hit = HELD_BITS'(b);
            end
        end
    end

    assign any_hit     = |hit;
    assign streak_bump = (streak_reg == rlbd_pkg::STREAK_MAX) ? rlbd_pkg::STREAK_MAX
                                                               : streak_reg + 1'b1;

    // debounce state update
    always_comb
    begin
        holding_next = holding_reg;
        streak_next  = streak_reg;
        held_next    = held_reg;
        emit         = 1'b0;
        emit_button  = held_reg;
        if (holding_reg)
        begin
            streak_next = hit[held_reg] ? '0 : streak_bump;
            if (streak_next >= release_count_reg)
            begin
                emit         = 1'b1;
                streak_next  = '0;
                holding_next = 1'b0;
            end
        end
        else if (any_hit)
        begin
            streak_next = streak_bump;
            emit_button = first_hit;
            if (streak_next >= press_count_reg)
            begin
                emit         = 1'b1;
                streak_next  = '0;
                holding_next = 1'b1;
                held_next    = first_hit;
            end
        end
        else
        begin
            streak_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
            streak_reg  <= '0;
            held_reg    <= '0;
        end
        else if (advance)
        begin
            holding_reg <= holding_next;
            streak_reg  <= streak_next;
            held_reg    <= held_next;
        end
    end

    // result word fields
    always_comb
    begin
        out_valid_next = advance ? emit : (out_valid_reg && !events.ready);
        out_kind_next  = holding_reg ? rlbd_pkg::KIND_RELEASE : rlbd_pkg::KIND_PRESS;
        out_index_next = rlbd_pkg::BUTTON_INDEX_BITS'(emit_button);
        out_type_next  = entry_reg[emit_button][2*SAMPLE_BITS];
        out_code_next  = entry_reg[emit_button][ENTRY_BITS-1:2*SAMPLE_BITS+1];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg  <= out_kind_next;
            out_index_reg <= out_index_next;
            out_type_reg  <= out_type_next;
            out_code_reg  <= out_code_next;
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.event_kind   = out_kind_reg;
    assign events.button_index = out_index_reg;
    assign events.output_type  = out_type_reg;
    assign events.key_code     = out_code_reg;

    // checks on the debounce state
    `ASSERT_IMPLIES_NEXT(a_press_enters_hold, clk, rst_n,
        advance && emit && !holding_reg, holding_reg && (streak_reg == '0))
    `ASSERT_IMPLIES_NEXT(a_release_leaves_hold, clk, rst_n,
        advance && emit && holding_reg, !holding_reg && (streak_reg == '0))
    `ASSERT_IMPLIES_NEXT(a_state_holds_without_word, clk, rst_n,
        !advance, $stable(holding_reg) && $stable(streak_reg) && $stable(held_reg))

endmodule

[tb/resistor_ladder_button_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resistor_ladder_button_decoder_unit_test
// Self-checking bench for the debounced resistor ladder button decoder
// ----------------------------------------------------------------------------
// A short table of hand-picked samples runs first on the reset settings,
// then a series of register settings, each followed by random press and
// release sequences mixed with noise. An internal decoder model predicts every
// press and release word not typed in the table; each word from the event channel
// is compared against the oldest prediction. Both channels idle at random,
// and the event side holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module resistor_ladder_button_decoder_unit_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int NUM_SETTINGS = 8;
    localparam int RANDOM_ITEMS = 1330;
    localparam int NUM_ROWS     = 22;

    // register indexes of the write port
    localparam logic [2:0] REG_ENTRY_0 = 3'd0;
    localparam logic [2:0] REG_PRESS   = 3'd4;
    localparam logic [2:0] REG_RELEASE = 3'd5;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                                   kind;
        logic [rlbd_pkg::BUTTON_INDEX_BITS-1:0] button;
        logic                                   out_type;
        logic [rlbd_pkg::KEY_CODE_BITS-1:0]     code;
    } button_event_t;

    typedef struct packed {
        logic [9:0]    sample;
        logic          typed;
        logic          fires;
        button_event_t ev;
    } stim_row_t;

    localparam button_event_t NO_EVENT = '0;

    // directed samples on the reset settings; expected words typed where obvious
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{10'd0,    1'b1, 1'b0, NO_EVENT},
        '{10'd1023, 1'b1, 1'b0, NO_EVENT},
        '{10'd950,  1'b0, 1'b0, NO_EVENT},
        '{10'd950,  1'b0, 1'b0, NO_EVENT},
        '{10'd950,  1'b0, 1'b0, NO_EVENT},
        '{10'd950,  1'b1, 1'b1, '{rlbd_pkg::KIND_PRESS, 2'd0, 1'b1, 8'd201}},
        '{10'd955,  1'b0, 1'b0, NO_EVENT},
        '{10'd0,    1'b0, 1'b0, NO_EVENT},
        '{10'd1023, 1'b0, 1'b0, NO_EVENT},
        '{10'd0,    1'b0, 1'b0, NO_EVENT},
        '{10'd1023, 1'b1, 1'b1, '{rlbd_pkg::KIND_RELEASE, 2'd0, 1'b1, 8'd201}},
        '{10'd945,  1'b0, 1'b0, NO_EVENT},
        '{10'd946,  1'b0, 1'b0, NO_EVENT},
        '{10'd946,  1'b0, 1'b0, NO_EVENT},
        '{10'd946,  1'b0, 1'b0, NO_EVENT},
        '{10'd1000, 1'b1, 1'b1, '{rlbd_pkg::KIND_PRESS, 2'd1, 1'b1, 8'd200}},
        '{10'd1020, 1'b0, 1'b0, NO_EVENT},
        '{10'd985,  1'b0, 1'b0, NO_EVENT},
        '{10'd1021, 1'b0, 1'b0, NO_EVENT},
        '{10'd0,    1'b1, 1'b1, '{rlbd_pkg::KIND_RELEASE, 2'd1, 1'b1, 8'd200}},
        '{10'd964,  1'b0, 1'b0, NO_EVENT},
        '{10'd965,  1'b0, 1'b0, NO_EVENT}
    };

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [2:0] wr_index;
    logic [28:0] wr_data;

    rlbd_sample_if #(.SAMPLE_BITS(10)) samples_ch ();
    rlbd_event_if events_ch ();

    resistor_ladder_button_decoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .events   (events_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // decoder model state and register shadow
    logic [28:0] entry_cfg [4];
    logic [3:0]  press_thr;
    logic [3:0]  release_thr;
    logic        holding;
    logic [3:0]  streak;
    logic [1:0]  held_button;

    button_event_t pending_events [$];

    int   mismatches  = 0;
    int   samples_sent;
    int   events_seen = 0;
    int   reg_writes;
    int   settings_used;
    int   cycle_count = 0;
    int   source_mode;
    int   sink_mode;
    int   sink_wait   = 0;
    logic hold_events;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycle_count,
                     pending_events.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic int draw_wait(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic bit window_hit(input int b, input logic [9:0] s);
        return s > entry_cfg[b][9:0] && s < entry_cfg[b][19:10];
    endfunction

    function automatic button_event_t make_event(input logic kind, input int b);
        button_event_t ev;
        ev.kind     = kind;
        ev.button   = 2'(b);
        ev.out_type = entry_cfg[b][20];
        ev.code     = entry_cfg[b][28:21];
        return ev;
    endfunction

    function automatic logic [3:0] bumped(input logic [3:0] v);
        return (v == rlbd_pkg::STREAK_MAX) ? rlbd_pkg::STREAK_MAX : v + 4'd1;
    endfunction

    // advance the decoder model by one sample; returns 1 when a word is due
    function automatic bit decode_sample(input logic [9:0] s, output button_event_t ev);
        int hit;
        ev  = NO_EVENT;
        hit = -1;
        if (holding)
        begin
            streak = window_hit(held_button, s) ? 4'd0 : bumped(streak);
            if (streak >= release_thr)
            begin
                ev      = make_event(rlbd_pkg::KIND_RELEASE, held_button);
                streak  = 4'd0;
                holding = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        for (int b = 3; b >= 0; b--)
            if (window_hit(b, s))
                hit = b;
        if (hit < 0)
        begin
            streak = 4'd0;
            return 1'b0;
        end
        streak = bumped(streak);
        if (streak >= press_thr)
        begin
            ev          = make_event(rlbd_pkg::KIND_PRESS, hit);
            streak      = 4'd0;
            holding     = 1'b1;
            held_button = 2'(hit);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one sample word, predict on acceptance, then idle a drawn gap
    task automatic send_sample(input logic [9:0] s, input bit typed = 1'b0,
                               input bit fires = 1'b0, input button_event_t want = '0);
        button_event_t ev;
        bit            due;
        int            gap;
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        due = decode_sample(s, ev);
        if (typed)
        begin
            if (fires)
                pending_events.push_back(want);
        end
        else if (due)
            pending_events.push_back(ev);
        samples_sent++;
        gap = draw_wait(source_mode);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // event sink: check each word, then draw the stall before the next one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            events_ch.ready <= 1'b0;
        end
        else
        begin
            if (events_ch.valid && events_ch.ready)
            begin : take_word
                button_event_t got;
                button_event_t want;
                got = {events_ch.event_kind, events_ch.button_index,
                       events_ch.output_type, events_ch.key_code};
                events_seen++;
                if (pending_events.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", got));
                else
                begin
                    want = pending_events.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("event_kind %b, want %b",
                                                  got.kind, want.kind));
                    if (got.button !== want.button)
                        report_mismatch($sformatf("button_index %0d, want %0d",
                                                  got.button, want.button));
                    if (got.out_type !== want.out_type)
                        report_mismatch($sformatf("output_type %b, want %b",
                                                  got.out_type, want.out_type));
                    if (got.code !== want.code)
                        report_mismatch($sformatf("key_code %0d, want %0d",
                                                  got.code, want.code));
                end
                sink_wait = draw_wait(sink_mode);
            end
            else if (sink_wait > 0)
                sink_wait--;
            events_ch.ready <= (sink_wait == 0) && !hold_events;
        end
    end

    // one long hold-off on the event side while samples keep coming
    initial
    begin
        hold_events = 1'b0;
        wait (samples_sent >= 400);
        @(posedge clk);
        hold_events <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_events <= 1'b0;
    end

    // register write, mirrored into the shadow
    task automatic write_register(input logic [2:0] idx, input logic [28:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        reg_writes++;
        if (idx < REG_PRESS)
            entry_cfg[idx[1:0]] = data;
        else if (idx == REG_PRESS)
            press_thr = data[3:0];
        else if (idx == REG_RELEASE)
            release_thr = data[3:0];
    endtask

    // mostly narrow windows, sometimes a raw word
    function automatic logic [28:0] random_entry();
        int lo;
        int hi;
        if ($urandom_range(0, 7) == 0)
            return 29'($urandom);
        lo = $urandom_range(0, 1000);
        hi = lo + $urandom_range(0, 60);
        if (hi > 1023)
            hi = 1023;
        return {8'($urandom), 1'($urandom), 10'(hi), 10'(lo)};
    endfunction

    function automatic logic [9:0] pick_inside(input int b);
        int lo;
        int hi;
        lo = entry_cfg[b][9:0];
        hi = entry_cfg[b][19:10];
        if (hi > lo + 1)
            return 10'($urandom_range(lo + 1, hi - 1));
        return 10'($urandom);
    endfunction

    function automatic logic [9:0] pick_outside(input int b);
        logic [9:0] s;
        case ($urandom_range(0, 3))
            0: return entry_cfg[b][9:0];
            1: return entry_cfg[b][19:10];
            default:
            begin
                for (int tries = 0; tries < 16; tries++)
                begin
                    s = 10'($urandom);
                    if (!window_hit(b, s))
                        return s;
                end
                return entry_cfg[b][9:0];
            end
        endcase
    endfunction

    // press/release sequences with random content, broken ones and noise
    task automatic random_burst();
        int b;
        int n;
        int pick;
        pick = $urandom_range(0, 9);
        b    = $urandom_range(0, 3);
        if (pick < 7)
        begin
            n = press_thr + $urandom_range(0, 2);
            repeat (n) send_sample(pick_inside(b));
            repeat ($urandom_range(0, 3)) send_sample(pick_inside(b));
            n = release_thr + $urandom_range(0, 2);
            repeat (n) send_sample(pick_outside(b));
        end
        else if (pick < 9)
        begin
            n = $urandom_range(0, press_thr);
            repeat (n) send_sample(pick_inside(b));
            send_sample(pick_outside(b));
        end
        else
            repeat ($urandom_range(1, 6)) send_sample(10'($urandom));
    endtask

    // wait for every predicted word, then let the pipeline drain
    task automatic wait_idle();
        samples_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register settings, one per phase
    task automatic apply_setting(input int phase);
        case (phase)
            0:
            begin
                // overlapping windows, widest window, empty window, spare indexes
                write_register(REG_ENTRY_0,        {8'd255, 1'b0, 10'd200, 10'd100});
                write_register(REG_ENTRY_0 + 3'd1, {8'd0,   1'b1, 10'd300, 10'd150});
                write_register(REG_ENTRY_0 + 3'd2, {8'h55,  1'b0, 10'd1023, 10'd0});
                write_register(REG_ENTRY_0 + 3'd3, {8'hAA,  1'b1, 10'd501, 10'd500});
                write_register(REG_PRESS, 29'd1);
                write_register(REG_RELEASE, 29'd1);
                write_register(REG_SPARE_A, 29'h1FFF_FFFF);
                write_register(REG_SPARE_B, 29'h0AAA_AAAA);
            end
            1:
            begin
                for (int b = 0; b < 4; b++)
                    write_register(REG_ENTRY_0 + 3'(b), random_entry());
                write_register(REG_PRESS, 29'd15);
                write_register(REG_RELEASE, 29'd15);
            end
            2:
            begin
                // a zero press count fires on the first matching sample, a zero release count on any sample
                write_register(REG_ENTRY_0 + 3'd1, random_entry());
                write_register(REG_PRESS, 29'd0);
                write_register(REG_RELEASE, 29'd0);
            end
            default:
            begin
                for (int b = 0; b < 4; b++)
                    if ($urandom_range(0, 2) != 0)
                        write_register(REG_ENTRY_0 + 3'(b), random_entry());
                write_register(REG_PRESS, {25'($urandom), 4'($urandom_range(1, 15))});
                write_register(REG_RELEASE, {25'($urandom), 4'($urandom_range(1, 15))});
            end
        endcase
        wr_en <= 1'b0;
        settings_used++;
    endtask

    // main sequence
    initial
    begin
        rst_n             <= 1'b0;
        wr_en             <= 1'b0;
        wr_index          <= REG_ENTRY_0;
        wr_data           <= '0;
        samples_ch.valid  <= 1'b0;
        samples_ch.sample <= '0;
        samples_sent      = 0;
        reg_writes        = 0;
        settings_used     = 1;
        source_mode       = 1;
        sink_mode         = 1;
        for (int b = 0; b < 4; b++)
            entry_cfg[b] = {rlbd_pkg::RESET_CODE[b], rlbd_pkg::RESET_TYPE[b],
                            rlbd_pkg::RESET_HIGH[b][9:0], rlbd_pkg::RESET_LOW[b][9:0]};
        press_thr   = rlbd_pkg::PRESS_RESET;
        release_thr = rlbd_pkg::RELEASE_RESET;
        holding     = 1'b0;
        streak      = 4'd0;
        held_button = 2'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table on the reset settings
        for (int i = 0; i < NUM_ROWS; i++)
            send_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].fires,
                        DIRECTED[i].ev);

        // random sequences under each setting
        for (int phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            wait_idle();
            apply_setting(phase);
            while (samples_sent < NUM_ROWS + (phase + 1) * (RANDOM_ITEMS / NUM_SETTINGS))
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    source_mode = $urandom_range(0, 2);
                    sink_mode   = $urandom_range(0, 2);
                end
                random_burst();
            end
        end

        wait_idle();
        $display("covered %0d samples and %0d press/release words", samples_sent, events_seen);
        $display("over %0d register settings with %0d register writes", settings_used,
                 reg_writes);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[resistor_ladder_button_decoder_unit.f]
+incdir+design
design/rlbd_pkg.sv
design/rlbd_sample_if.sv
design/rlbd_event_if.sv
design/resistor_ladder_button_decoder_unit.sv
tb/resistor_ladder_button_decoder_unit_test.sv
